// File: hw/rtl/ked_pkg.sv
`timescale 1ns / 1ps

package ked_pkg;

    // Timestamp width on the port; internal time arithmetic uses TIME_WIDTH
    localparam int SAMPLE_W          = 32;
    localparam int TIME_WIDTH_DEF    = 32;
    localparam int CFG_W             = 16;

    localparam logic [5:0]  DEBOUNCE_GAP = 6'd50;
    localparam logic [1:0]  AGREE_NEEDED = 2'd3;
    localparam logic [15:0] MIN_LONG     = 16'd10;
    localparam logic [2:0]  TALLY_MAX    = 3'd4;

    localparam logic [15:0] LONG_PRESS_RST   = 16'd1000;
    localparam logic [15:0] CLICK_WINDOW_RST = 16'd0;

    // Configuration register indexes
    localparam logic REG_LONG_PRESS   = 1'b0;
    localparam logic REG_CLICK_WINDOW = 1'b1;

    // Event codes kept in the current/prior event registers
    localparam logic [3:0] EV_NONE         = 4'd0;
    localparam logic [3:0] EV_CLICK        = 4'd1;
    localparam logic [3:0] EV_LONG_WAIT    = 4'd2;
    localparam logic [3:0] EV_RELEASE      = 4'd3;
    localparam logic [3:0] EV_HOLD_RELEASE = 4'd4;
    localparam logic [3:0] EV_HOLD         = 4'd5;
    localparam logic [3:0] EV_CLICK_BASE   = 4'd5;

    localparam logic [2:0] CLICK_NONE = 3'd0;

    typedef struct packed {
        logic       level;
        logic [2:0] edge_ev;
        logic [2:0] click_ev;
    } ked_result_t;

endpackage

// File: hw/rtl/ked_core.sv
`timescale 1ns / 1ps

module ked_core import ked_pkg::*; #(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic [TIME_WIDTH-1:0] now,
    input  logic                  pin,
    input  logic [CFG_W-1:0]      long_press_ms,
    input  logic [CFG_W-1:0]      click_window_ms,
    output ked_result_t           res
);

    logic                  deb_reg, deb_next;
    logic [TIME_WIDTH-1:0] prev_tick_reg;
    logic [1:0]            pcnt_reg, pcnt_next;
    logic [1:0]            rcnt_reg, rcnt_next;
    logic [TIME_WIDTH-1:0] pstart_reg, pstart_next;
    logic [TIME_WIDTH-1:0] rstamp_reg, rstamp_next;
    logic                  lhf_reg, lhf_next;
    logic [TIME_WIDTH-1:0] lhs_reg, lhs_next;
    logic                  lhv_reg, lhv_next;
    logic [3:0]            cur_reg, cur_next;
    logic [3:0]            prior_reg, prior_next;
    logic                  phase_reg, phase_next;
    logic [2:0]            tally_reg, tally_next;
    logic [TIME_WIDTH-1:0] cws_reg, cws_next;

    logic [TIME_WIDTH-1:0] gap;
    logic [CFG_W-1:0]      eff, window;
    logic [TIME_WIDTH-1:0] eff_t, window_t, half_t;
    logic                  lockout;
    logic [3:0]            edge_code;
    logic [2:0]            click_code;

    assign gap      = now - prev_tick_reg;
    assign eff      = (long_press_ms < MIN_LONG) ? MIN_LONG : long_press_ms;
    assign window   = (click_window_ms != '0) ? click_window_ms : eff;
    assign eff_t    = TIME_WIDTH'(eff);
    assign window_t = TIME_WIDTH'(window);
    assign half_t   = TIME_WIDTH'(eff >> 1);

    // Debouncer
    always_comb begin
        logic [1:0] inc;
        inc         = 2'd0;
        deb_next    = deb_reg;
        pcnt_next   = pcnt_reg;
        rcnt_next   = rcnt_reg;
        pstart_next = pstart_reg;
        if (gap != '0) begin
            if (pin) begin
                if (!deb_reg) begin
                    inc = pcnt_reg + 2'd1;
                    if (gap >= TIME_WIDTH'(DEBOUNCE_GAP) || inc == AGREE_NEEDED) begin
                        pcnt_next   = 2'd0;
                        deb_next    = 1'b1;
                        pstart_next = now;
                    end else begin
                        pcnt_next = inc;
                    end
                end
                rcnt_next = 2'd0;
            end else begin
                if (deb_reg) begin
                    inc = rcnt_reg + 2'd1;
                    if (gap >= TIME_WIDTH'(DEBOUNCE_GAP) || inc == AGREE_NEEDED) begin
                        rcnt_next = 2'd0;
                        deb_next  = 1'b0;
                    end else begin
                        rcnt_next = inc;
                    end
                end
                pcnt_next = 2'd0;
            end
        end
    end

    // Presses are masked for half the long time after a long hold
    assign lockout = lhv_reg && deb_next && ((now - lhs_reg) < half_t);

    // Edge and click logic
    always_comb begin
        edge_code   = EV_NONE;
        click_code  = CLICK_NONE;
        rstamp_next = rstamp_reg;
        lhf_next    = lhf_reg;
        lhs_next    = lhs_reg;
        lhv_next    = lhv_reg;
        cur_next    = cur_reg;
        prior_next  = prior_reg;
        phase_next  = phase_reg;
        tally_next  = tally_reg;
        cws_next    = cws_reg;
        if (!lockout) begin
            if (deb_reg != deb_next) begin
                if (deb_next) begin
                    edge_code = ((now - rstamp_reg) >= eff_t) ? EV_LONG_WAIT : EV_CLICK;
                end else begin
                    rstamp_next = now;
                    if (lhf_reg) begin
                        lhf_next   = 1'b0;
                        edge_code  = EV_HOLD_RELEASE;
                        phase_next = 1'b0;
                    end else begin
                        edge_code = EV_RELEASE;
                    end
                end
                cur_next = edge_code;
            end else if (deb_next && !lhf_reg && ((now - pstart_next) >= eff_t)) begin
                lhf_next  = 1'b1;
                lhs_next  = now;
                lhv_next  = 1'b1;
                edge_code = EV_HOLD;
                cur_next  = edge_code;
            end

            if (!phase_next) begin
                if (prior_reg != cur_next && deb_next) begin
                    tally_next = 3'd0;
                    phase_next = 1'b1;
                    cws_next   = now;
                end
            end else if ((now - cws_reg) <= window_t) begin
                if (prior_reg != cur_next) begin
                    cws_next = now;
                    if (cur_next == EV_RELEASE && tally_reg < TALLY_MAX) begin
                        tally_next = tally_reg + 3'd1;
                    end
                end
            end else if (!deb_next) begin
                if (tally_reg != 3'd0) begin
                    click_code = tally_reg;
                    cur_next   = EV_CLICK_BASE + 4'(tally_reg);
                end
                tally_next = 3'd0;
                phase_next = 1'b0;
            end

            prior_next = cur_next;
        end
    end

    assign res.level    = deb_next;
    assign res.edge_ev  = edge_code[2:0];
    assign res.click_ev = click_code;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deb_reg       <= 1'b0;
            prev_tick_reg <= '0;
            pcnt_reg      <= 2'd0;
            rcnt_reg      <= 2'd0;
            pstart_reg    <= '0;
            rstamp_reg    <= '0;
            lhf_reg       <= 1'b0;
            lhs_reg       <= '0;
            lhv_reg       <= 1'b0;
            cur_reg       <= EV_NONE;
            prior_reg     <= EV_NONE;
            phase_reg     <= 1'b0;
            tally_reg     <= 3'd0;
            cws_reg       <= '0;
        end else if (en) begin
            deb_reg       <= deb_next;
            prev_tick_reg <= now;
            pcnt_reg      <= pcnt_next;
            rcnt_reg      <= rcnt_next;
            pstart_reg    <= pstart_next;
            rstamp_reg    <= rstamp_next;
            lhf_reg       <= lhf_next;
            lhs_reg       <= lhs_next;
            lhv_reg       <= lhv_next;
            cur_reg       <= cur_next;
            prior_reg     <= prior_next;
            phase_reg     <= phase_next;
            tally_reg     <= tally_next;
            cws_reg       <= cws_next;
        end
    end

`ifndef ASSERT_OFF
    a_agree_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        pcnt_reg != AGREE_NEEDED && rcnt_reg != AGREE_NEEDED)
        else $error("debounce agree count reached its limit unnoticed");

    a_tally_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        tally_reg <= TALLY_MAX)
        else $error("click tally beyond saturation");

    a_hold_stamp: assert property (@(posedge aclk) disable iff (!aresetn)
        lhf_reg |-> lhv_reg)
        else $error("long hold flagged without a stamp on record");

    a_hold_pressed: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && res.edge_ev == EV_HOLD[2:0]) |-> res.level)
        else $error("long hold reported while released");

    a_click_released: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && res.click_ev != CLICK_NONE) |=> !deb_reg)
        else $error("click report while key pressed");
`endif

endmodule

// File: hw/rtl/key_event_detector_unit.sv
`timescale 1ns / 1ps

// Single-key debounce, edge, long-hold and multi-click detector. Each input
// transfer is one poll tick (timestamp plus raw pin) and yields exactly one
// result transfer. The block takes one tick per clock unless the output side
// stalls: the tick is captured in an input register, evaluated against the key
// state in one pass of combinational logic, and the result lands in an output
// register. A new tick is taken whenever the input register is empty or
// moves on in the same cycle. Configuration writes are immediate and should
// only be issued while no tick is in flight.

module key_event_detector_unit import ked_pkg::*; #(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [SAMPLE_W-1:0] s_sample_time,
    input  logic                s_raw_pin,

    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_debounced_level,
    output logic [2:0]          m_edge_event,
    output logic [2:0]          m_click_event,

    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_wdata
);

    logic [CFG_W-1:0]      long_press_reg;
    logic [CFG_W-1:0]      click_window_reg;

    logic                  in_valid_reg;
    logic [TIME_WIDTH-1:0] in_time_reg;
    logic                  in_pin_reg;
    logic [TIME_WIDTH-1:0] now_in;

    logic                  out_valid_reg;
    ked_result_t           out_reg;
    ked_result_t           res;
    logic                  advance;

    if (TIME_WIDTH > SAMPLE_W) begin : g_time_ext
        assign now_in = {{(TIME_WIDTH - SAMPLE_W){1'b0}}, s_sample_time};
    end else begin : g_time_trunc
        assign now_in = s_sample_time[TIME_WIDTH-1:0];
    end

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_press_reg   <= LONG_PRESS_RST;
            click_window_reg <= CLICK_WINDOW_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_LONG_PRESS:   long_press_reg   <= cfg_wdata;
                REG_CLICK_WINDOW: click_window_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_time_reg <= now_in;
            in_pin_reg  <= s_raw_pin;
        end
    end

    ked_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .en              (advance),
        .now             (in_time_reg),
        .pin             (in_pin_reg),
        .long_press_ms   (long_press_reg),
        .click_window_ms (click_window_reg),
        .res             (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_debounced_level = out_reg.level;
    assign m_edge_event      = out_reg.edge_ev;
    assign m_click_event     = out_reg.click_ev;

endmodule
